>>> design/gbcb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbcb_pkg
// Shared types, constants and the microcode program of the glyph blitter.
// ----------------------------------------------------------------------------
package gbcb_pkg;

    // Default geometry of the frame and font stores
    localparam int H_RES_DEF      = 256;
    localparam int V_RES_DEF      = 128;
    localparam int FONT_BYTES_DEF = 2048;

    // Fixed field widths
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 4;
    localparam int IN_DATA_W = 64;
    localparam int IN_USER_W = 2;
    localparam int OUT_W     = 16;

    // Blend and glyph constants
    localparam logic [7:0] ERROR_COLOR  = 8'h2A;
    localparam logic [1:0] ALPHA_KEEP   = 2'b11;
    localparam logic [1:0] ALPHA_OPAQUE = 2'b00;
    localparam logic [3:0] GLYPH_MAX    = 4'd8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 1'b1;

    // Operation codes carried in tuser
    typedef enum logic [1:0] {
        OP_DRAW = 2'd0,
        OP_LOAD = 2'd1,
        OP_READ = 2'd2
    } op_t;

    // Datapath actions selected by the control word
    typedef enum logic [3:0] {
        ACT_NONE    = 4'd0,
        ACT_CLEAR   = 4'd1,
        ACT_ACCEPT  = 4'd2,
        ACT_SETUP   = 4'd3,
        ACT_LOAD    = 4'd4,
        ACT_BITADDR = 4'd5,
        ACT_MOD     = 4'd6,
        ACT_FETCH   = 4'd7,
        ACT_BLEND   = 4'd8,
        ACT_PRESENT = 4'd9,
        ACT_RDCAP   = 4'd10
    } act_t;

    // Jump conditions
    typedef enum logic [3:0] {
        C_NEVER    = 4'd0,
        C_ALWAYS   = 4'd1,
        C_CLR_BUSY = 4'd2,
        C_NO_ITEM  = 4'd3,
        C_OP_READ  = 4'd4,
        C_NOT_DRAW = 4'd5,
        C_EMPTY    = 4'd6,
        C_BYTE_GE  = 4'd7,
        C_MORE     = 4'd8,
        C_OUT_BUSY = 4'd9
    } cond_t;

    typedef logic [3:0] step_t;

    // Program addresses
    localparam step_t S_CLR   = 4'd0;
    localparam step_t S_IDLE  = 4'd1;
    localparam step_t S_SETUP = 4'd2;
    localparam step_t S_LOAD  = 4'd3;
    localparam step_t S_BIT   = 4'd4;
    localparam step_t S_MOD   = 4'd5;
    localparam step_t S_FETCH = 4'd6;
    localparam step_t S_BLEND = 4'd7;
    localparam step_t S_OUT   = 4'd8;
    localparam step_t S_RET   = 4'd9;
    localparam step_t S_RD0   = 4'd10;
    localparam step_t S_RD1   = 4'd11;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        step_t target;
    } ctl_word_t;

    // Datapath flags seen by the sequencer
    typedef struct packed {
        logic accept;
        logic clr_busy;
        logic op_read;
        logic not_draw;
        logic empty;
        logic byte_ge;
        logic more;
        logic out_busy;
    } status_t;

    // Microcode program: taken jump goes to target, else fall through
    function automatic ctl_word_t ucode_rom(input step_t step);
        ctl_word_t w;
        case (step)
            S_CLR:   w = '{ACT_CLEAR,   C_CLR_BUSY, S_CLR};
            S_IDLE:  w = '{ACT_ACCEPT,  C_NO_ITEM,  S_IDLE};
            S_SETUP: w = '{ACT_SETUP,   C_OP_READ,  S_RD0};
            S_LOAD:  w = '{ACT_LOAD,    C_NOT_DRAW, S_OUT};
            S_BIT:   w = '{ACT_BITADDR, C_EMPTY,    S_OUT};
            S_MOD:   w = '{ACT_MOD,     C_BYTE_GE,  S_MOD};
            S_FETCH: w = '{ACT_FETCH,   C_NEVER,    S_BLEND};
            S_BLEND: w = '{ACT_BLEND,   C_MORE,     S_FETCH};
            S_OUT:   w = '{ACT_PRESENT, C_OUT_BUSY, S_OUT};
            S_RET:   w = '{ACT_NONE,    C_ALWAYS,   S_IDLE};
            S_RD0:   w = '{ACT_FETCH,   C_NEVER,    S_RD1};
            S_RD1:   w = '{ACT_RDCAP,   C_ALWAYS,   S_OUT};
            default: w = '{ACT_NONE,    C_ALWAYS,   S_IDLE};
        endcase
        return w;
    endfunction

endpackage

>>> design/gbcb_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbcb_seq
// Step counter and control store; issues one control word per cycle.
// ----------------------------------------------------------------------------
module gbcb_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  gbcb_pkg::status_t status,
    output gbcb_pkg::act_t    act
);
    import gbcb_pkg::*;

    step_t     step_reg;
    step_t     step_next;
    ctl_word_t ctl;
    logic      take;

    // Fetch the control word of the current step
    assign ctl = ucode_rom(step_reg);
    assign act = ctl.act;

    // Evaluate the jump condition
    always_comb
    begin
        case (ctl.cond)
            C_NEVER:    take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_CLR_BUSY: take = status.clr_busy;
            C_NO_ITEM:  take = !status.accept;
            C_OP_READ:  take = status.op_read;
            C_NOT_DRAW: take = status.not_draw;
            C_EMPTY:    take = status.empty;
            C_BYTE_GE:  take = status.byte_ge;
            C_MORE:     take = status.more;
            C_OUT_BUSY: take = status.out_busy;
            default:    take = 1'b1;
        endcase
        step_next = take ? ctl.target : step_t'(step_reg + 4'd1);
    end

    // Advance the step counter; reset enters the frame clear loop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_CLR;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

>>> design/gbcb_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbcb_dp
// Datapath: stream ports, configuration, font and frame stores, blend logic.
// ----------------------------------------------------------------------------
module gbcb_dp #(
    parameter int H_RES      = gbcb_pkg::H_RES_DEF,
    parameter int V_RES      = gbcb_pkg::V_RES_DEF,
    parameter int FONT_BYTES = gbcb_pkg::FONT_BYTES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  gbcb_pkg::act_t                   act,
    output gbcb_pkg::status_t                status,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [gbcb_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  logic [gbcb_pkg::IN_USER_W-1:0]   s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [gbcb_pkg::OUT_W-1:0]       m_axis_tdata,
    input  logic                             cfg_write,
    input  logic [gbcb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gbcb_pkg::CFG_W-1:0]       cfg_data
);
    import gbcb_pkg::*;

    localparam int DEPTH = H_RES * V_RES;
    localparam int FR_W  = $clog2(DEPTH);
    localparam int FA_W  = $clog2(FONT_BYTES);
    // Byte index must hold the full glyph byte address and the font size itself
    localparam int LW    = (FA_W + 1 > 12) ? FA_W + 1 : 12;
    localparam logic [FR_W-1:0] HRES_C    = FR_W'(H_RES);
    localparam logic [FR_W-1:0] CLR_LAST  = FR_W'(DEPTH - 1);
    localparam logic [LW-1:0]   FB_C      = LW'(FONT_BYTES);
    localparam logic [LW-1:0]   FB_LAST   = LW'(FONT_BYTES - 1);
    localparam logic [10:0]     HRES_CMP  = 11'(H_RES);
    localparam logic [10:0]     VRES_CMP  = 11'(V_RES);

    // Memories
    logic [7:0] frame_mem [DEPTH];
    logic [7:0] font_mem  [FONT_BYTES];

    // Control registers
    logic [FR_W-1:0] clr_reg, clr_next;
    logic            out_valid_reg, out_valid_next;
    logic [3:0]      glyph_w_reg, glyph_w_next;
    logic [3:0]      glyph_h_reg, glyph_h_next;

    // Item and working registers
    logic [1:0]        op_reg, op_next;
    logic [7:0]        code_reg, code_next;
    logic signed [9:0] x0_reg, x0_next;
    logic signed [9:0] y0_reg, y0_next;
    logic [7:0]        back_reg, back_next;
    logic [7:0]        fore_reg, fore_next;
    logic [10:0]       faddr_reg, faddr_next;
    logic [7:0]        fbyte_reg, fbyte_next;
    logic [3:0]        w_cl_reg, w_cl_next;
    logic [3:0]        h_cl_reg, h_cl_next;
    logic [6:0]        wh_reg, wh_next;
    logic [2:0]        col_reg, col_next;
    logic [2:0]        row_reg, row_next;
    logic signed [10:0] cur_x_reg, cur_x_next;
    logic signed [10:0] cur_y_reg, cur_y_next;
    logic [LW-1:0]     byte_reg, byte_next;
    logic [2:0]        bofs_reg, bofs_next;
    logic              vis_reg, vis_next;
    logic [FR_W-1:0]   paddr_reg, paddr_next;
    logic [6:0]        count_reg, count_next;
    logic [7:0]        pix_reg, pix_next;
    logic              inr_reg, inr_next;
    logic [6:0]        out_count_reg, out_count_next;
    logic [7:0]        out_pix_reg, out_pix_next;
    logic              out_inr_reg, out_inr_next;

    // Memory read data
    logic [7:0] font_rdata_reg;
    logic [7:0] frame_rdata_reg;

    // Combinational helpers
    logic            accept;
    logic            out_busy;
    logic            on_screen;
    logic [FR_W-1:0] pix_addr;
    logic [14:0]     bit_full;
    logic [LW-1:0]   load_addr;
    logic            load_ok;
    logic            last_col;
    logic            last_row;
    logic            glyph_bit;
    logic [7:0]      new_color;
    logic [7:0]      blended;
    logic [3:0]      w_clamp;
    logic [3:0]      h_clamp;
    logic            frame_we;
    logic [FR_W-1:0] frame_waddr;
    logic [7:0]      frame_wdata;
    logic            font_we;

    // Blend a new color over an existing frame pixel
    function automatic logic [7:0] blend(input logic [7:0] old, input logic [7:0] neu);
        logic [7:0] res;
        if (old[6])
        begin
            res = neu;
        end
        else if (neu[7:6] == ALPHA_OPAQUE)
        begin
            res = neu;
        end
        else if (neu[7:6] == ALPHA_KEEP)
        begin
            res = old;
        end
        else
        begin
            res = ERROR_COLOR;
        end
        return res;
    endfunction

    // Handshake
    assign s_axis_tready = (act == ACT_ACCEPT);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_busy      = out_valid_reg && !m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_inr_reg, out_pix_reg, out_count_reg};

    // Position, address and glyph helpers
    assign on_screen = !cur_x_reg[10] && !cur_y_reg[10]
                       && (11'(cur_x_reg[9:0]) < HRES_CMP)
                       && (11'(cur_y_reg[9:0]) < VRES_CMP);
    assign pix_addr  = FR_W'(cur_y_reg[9:0]) * HRES_C + FR_W'(cur_x_reg[9:0]);
    assign bit_full  = 15'(code_reg) * 15'(wh_reg) + 15'(w_cl_reg);
    assign load_addr = LW'(faddr_reg);
    assign load_ok   = load_addr < FB_C;
    assign last_col  = 4'(col_reg) == w_cl_reg - 4'd1;
    assign last_row  = 4'(row_reg) == h_cl_reg - 4'd1;
    assign glyph_bit = font_rdata_reg[bofs_reg];
    assign new_color = glyph_bit ? fore_reg : back_reg;
    assign blended   = blend(frame_rdata_reg, new_color);
    assign w_clamp   = (glyph_w_reg > GLYPH_MAX) ? GLYPH_MAX : glyph_w_reg;
    assign h_clamp   = (glyph_h_reg > GLYPH_MAX) ? GLYPH_MAX : glyph_h_reg;

    // Status toward the sequencer
    assign status.accept   = accept;
    assign status.clr_busy = clr_reg != CLR_LAST;
    assign status.op_read  = op_reg == OP_READ;
    assign status.not_draw = op_reg != OP_DRAW;
    assign status.empty    = (w_cl_reg == 4'd0) || (h_cl_reg == 4'd0);
    assign status.byte_ge  = byte_reg >= FB_C;
    assign status.more     = !(last_col && last_row);
    assign status.out_busy = out_busy;

    // Memory write controls
    assign frame_we    = (act == ACT_CLEAR) || ((act == ACT_BLEND) && vis_reg);
    assign frame_waddr = (act == ACT_CLEAR) ? clr_reg : paddr_reg;
    assign frame_wdata = (act == ACT_CLEAR) ? 8'd0 : blended;
    assign font_we     = (act == ACT_LOAD) && (op_reg == OP_LOAD) && load_ok;

    // Next-state logic for all registers
    always_comb
    begin
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg;
        glyph_w_next   = glyph_w_reg;
        glyph_h_next   = glyph_h_reg;
        op_next        = op_reg;
        code_next      = code_reg;
        x0_next        = x0_reg;
        y0_next        = y0_reg;
        back_next      = back_reg;
        fore_next      = fore_reg;
        faddr_next     = faddr_reg;
        fbyte_next     = fbyte_reg;
        w_cl_next      = w_cl_reg;
        h_cl_next      = h_cl_reg;
        wh_next        = wh_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        byte_next      = byte_reg;
        bofs_next      = bofs_reg;
        vis_next       = vis_reg;
        paddr_next     = paddr_reg;
        count_next     = count_reg;
        pix_next       = pix_reg;
        inr_next       = inr_reg;
        out_count_next = out_count_reg;
        out_pix_next   = out_pix_reg;
        out_inr_next   = out_inr_reg;

        // Configuration writes
        if (cfg_write && (cfg_index == REG_GLYPH_WIDTH))
        begin
            glyph_w_next = cfg_data;
        end
        if (cfg_write && (cfg_index == REG_GLYPH_HEIGHT))
        begin
            glyph_h_next = cfg_data;
        end

        // Drop the output word once taken
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (act)
            ACT_CLEAR:
            begin
                clr_next = FR_W'(clr_reg + 1'b1);
            end
            ACT_ACCEPT:
            begin
                if (accept)
                begin
                    op_next    = s_axis_tuser;
                    code_next  = s_axis_tdata[7:0];
                    x0_next    = s_axis_tdata[17:8];
                    y0_next    = s_axis_tdata[27:18];
                    back_next  = s_axis_tdata[35:28];
                    fore_next  = s_axis_tdata[43:36];
                    faddr_next = s_axis_tdata[54:44];
                    fbyte_next = s_axis_tdata[62:55];
                end
            end
            ACT_SETUP:
            begin
                w_cl_next  = w_clamp;
                h_cl_next  = h_clamp;
                wh_next    = 7'(w_clamp) * 7'(h_clamp);
                col_next   = 3'd0;
                row_next   = 3'd0;
                cur_x_next = {x0_reg[9], x0_reg};
                cur_y_next = {y0_reg[9], y0_reg};
                count_next = 7'd0;
                pix_next   = 8'd0;
                inr_next   = 1'b0;
            end
            ACT_BITADDR:
            begin
                byte_next = LW'(bit_full[14:3]);
                bofs_next = bit_full[2:0];
            end
            ACT_MOD:
            begin
                if (byte_reg >= FB_C)
                begin
                    byte_next = byte_reg - FB_C;
                end
            end
            ACT_FETCH:
            begin
                vis_next   = on_screen;
                paddr_next = pix_addr;
            end
            ACT_BLEND:
            begin
                if (vis_reg)
                begin
                    count_next = 7'(count_reg + 7'd1);
                end
                // Advance through the bit stream
                bofs_next = 3'(bofs_reg + 3'd1);
                if (bofs_reg == 3'd7)
                begin
                    byte_next = (byte_reg == FB_LAST) ? '0 : LW'(byte_reg + 1'b1);
                end
                // Advance column, wrap to next row
                if (last_col)
                begin
                    col_next   = 3'd0;
                    row_next   = 3'(row_reg + 3'd1);
                    cur_x_next = {x0_reg[9], x0_reg};
                    cur_y_next = 11'(cur_y_reg + 11'sd1);
                end
                else
                begin
                    col_next   = 3'(col_reg + 3'd1);
                    cur_x_next = 11'(cur_x_reg + 11'sd1);
                end
            end
            ACT_RDCAP:
            begin
                pix_next = vis_reg ? frame_rdata_reg : 8'd0;
                inr_next = vis_reg;
            end
            ACT_PRESENT:
            begin
                if (!out_busy)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = count_reg;
                    out_pix_next   = pix_reg;
                    out_inr_next   = inr_reg;
                end
            end
            default:
            begin
                clr_next = clr_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            glyph_w_reg   <= GLYPH_MAX;
            glyph_h_reg   <= GLYPH_MAX;
        end
        else
        begin
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            glyph_w_reg   <= glyph_w_next;
            glyph_h_reg   <= glyph_h_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        code_reg      <= code_next;
        x0_reg        <= x0_next;
        y0_reg        <= y0_next;
        back_reg      <= back_next;
        fore_reg      <= fore_next;
        faddr_reg     <= faddr_next;
        fbyte_reg     <= fbyte_next;
        w_cl_reg      <= w_cl_next;
        h_cl_reg      <= h_cl_next;
        wh_reg        <= wh_next;
        col_reg       <= col_next;
        row_reg       <= row_next;
        cur_x_reg     <= cur_x_next;
        cur_y_reg     <= cur_y_next;
        byte_reg      <= byte_next;
        bofs_reg      <= bofs_next;
        vis_reg       <= vis_next;
        paddr_reg     <= paddr_next;
        count_reg     <= count_next;
        pix_reg       <= pix_next;
        inr_reg       <= inr_next;
        out_count_reg <= out_count_next;
        out_pix_reg   <= out_pix_next;
        out_inr_reg   <= out_inr_next;
    end

    // Frame store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (frame_we)
        begin
            frame_mem[frame_waddr] <= frame_wdata;
        end
        frame_rdata_reg <= frame_mem[pix_addr];
    end

    // Font store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (font_we)
        begin
            font_mem[load_addr[FA_W-1:0]] <= fbyte_reg;
        end
        font_rdata_reg <= font_mem[byte_reg[FA_W-1:0]];
    end

endmodule

>>> design/glyph_blitter_with_clip_blend_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_blitter_with_clip_blend_unit
// Glyph blitter with clipping and alpha blend into an 8-bit frame store.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_axis; tuser holds the operation (draw glyph,
//   load font byte, read pixel) and tdata the item fields. Every input word
//   yields exactly one output word on m_axis.
//   Glyph size is set through the cfg_write/cfg_index/cfg_data port while
//   the block is idle; both sizes reset to 8.
//   One word is worked on at a time. A draw passes the setup, load and bit
//   address steps, then a modulo step that subtracts FONT_BYTES from its
//   first glyph byte address until it is in range; each glyph pixel costs
//   a fetch step and a blend step. An empty draw and a read (fetch, then
//   capture) skip the pixel loop; a load or unused operation goes from the
//   load step to output. A return step then leads to idle and the next word.
//   After reset a clear pass writes zero to all H_RES*V_RES frame entries,
//   one per cycle; s_axis_tready stays low meanwhile. The output register
//   holds a finished word while m_axis_tready is low; the sequencer waits
//   in its output step until the register frees.
// ----------------------------------------------------------------------------
module glyph_blitter_with_clip_blend_unit #(
    parameter int H_RES      = gbcb_pkg::H_RES_DEF,
    parameter int V_RES      = gbcb_pkg::V_RES_DEF,
    parameter int FONT_BYTES = gbcb_pkg::FONT_BYTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // char_code[7:0], pos_x[17:8], pos_y[27:18], back_color[35:28],
    // fore_color[43:36], font_address[54:44], font_byte[62:55], zero[63]
    input  logic [gbcb_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // operation[1:0]
    input  logic [gbcb_pkg::IN_USER_W-1:0] s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // pixels_written[6:0], pixel_color[14:7], in_range[15]
    output logic [gbcb_pkg::OUT_W-1:0]     m_axis_tdata,
    input  logic                           cfg_write,
    input  logic [gbcb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gbcb_pkg::CFG_W-1:0]     cfg_data
);
    import gbcb_pkg::*;

    act_t    act;
    status_t status;

    // Microcode sequencer
    gbcb_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .act    (act)
    );

    // Datapath with font and frame stores
    gbcb_dp #(
        .H_RES      (H_RES),
        .V_RES      (V_RES),
        .FONT_BYTES (FONT_BYTES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .act           (act),
        .status        (status),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

endmodule

>>> design/gbcb_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbcb_chk
// Port-level checks of the glyph blitter, bound to the top level.
// ----------------------------------------------------------------------------
module gbcb_chk (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [gbcb_pkg::OUT_W-1:0]     m_axis_tdata
);
    import gbcb_pkg::*;

    // Stalled output word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // One word in flight: ready drops right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second word accepted back to back");

    // Off-screen or non-read results carry no pixel color
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[15] |-> m_axis_tdata[14:7] == 8'd0)
        else $error("pixel color without in_range");

    // A successful read reports no drawn pixels
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[15] |-> m_axis_tdata[6:0] == 7'd0)
        else $error("read result with nonzero pixel count");

    // A glyph never blends more than 64 pixels
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[6:0] <= 7'd64)
        else $error("pixel count above glyph size");

endmodule

bind glyph_blitter_with_clip_blend_unit gbcb_chk u_gbcb_chk (.*);
